// ----- design/bmp_rle8_decoder_core_defines.svh -----
// Assertion macros for the BMP RLE8 decoder core.
// Needs clk_i and rst_ni in the module that includes it.
`ifndef BMP_RLE8_DECODER_CORE_DEFINES_SVH
`define BMP_RLE8_DECODER_CORE_DEFINES_SVH

// Property checked at every rising edge outside reset
`define BMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bmprle8_pkg.sv -----
// Shared types and constants of the BMP RLE8 decoder.
// No dependencies; imported by every module of the block.
package bmprle8_pkg;

  localparam int CFG_W       = 13;
  localparam int PROD_W      = 21;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [1:0] OP_PALETTE = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOI   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [1:0] {
    CMD_PALETTE,
    CMD_BYTE,
    CMD_START
  } cmd_kind_e;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_COLOR,
    PH_ESCAPE,
    PH_DX,
    PH_DY,
    PH_ABS,
    PH_PAD
  } phase_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } bmprle8_in_t;

  typedef struct packed {
    logic [23:0] pixel_offset;
    logic [7:0]  run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        image_done;
  } bmprle8_out_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data_byte;
    logic [PROD_W-1:0] row_step;
    logic [7:0]        pal_index;
    logic [23:0]       pal_rgb;
  } bmprle8_cmd_t;

endpackage

// ----- design/bmprle8_front.sv -----
// Front end: accepts beats, classifies them and queues commands.
// Depends on bmprle8_pkg.
module bmprle8_front import bmprle8_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bmprle8_in_t        in_data_i,
  input  logic [CFG_W-1:0]   img_width_i,
  output logic               cmd_valid_o,
  output bmprle8_cmd_t       cmd_o,
  input  logic               cmd_pop_i
);

  bmprle8_cmd_t          queue_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     cnt_q, cnt_d;
  logic                  accept;
  logic                  push;
  logic                  pop;
  bmprle8_cmd_t          entry;

  assign in_stall_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    entry           = '0;
    entry.kind      = CMD_BYTE;
    push            = accept;
    entry.data_byte = in_data_i.data_byte;
    entry.row_step  = PROD_W'(in_data_i.data_byte) * PROD_W'(img_width_i);
    entry.pal_index = in_data_i.palette_index;
    entry.pal_rgb   = {in_data_i.palette_red, in_data_i.palette_green,
                       in_data_i.palette_blue};
    unique case (in_data_i.operation)
      OP_PALETTE: entry.kind = CMD_PALETTE;
      OP_BYTE:    entry.kind = CMD_BYTE;
      OP_START:   entry.kind = CMD_START;
      default:    push = 1'b0;
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QUEUE_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QUEUE_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ----- design/bmprle8_back.sv -----
// Back end: RLE8 parser state, palette memory and result register.
// Depends on bmprle8_pkg and bmp_rle8_decoder_core_defines.svh.
`include "bmp_rle8_decoder_core_defines.svh"

module bmprle8_back import bmprle8_pkg::*; #(
  parameter int POS_W         = 25,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bmprle8_cmd_t       cmd_i,
  output logic               cmd_pop_o,
  input  logic [CFG_W-1:0]   img_width_i,
  input  logic [POS_W-1:0]   img_total_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bmprle8_out_t       out_data_o
);

  localparam int SUM_W  = ((POS_W > PROD_W) ? POS_W : PROD_W) + 2;
  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  phase_e             phase_q, phase_d;
  logic [7:0]         pend_q, pend_d;
  logic [7:0]         abs_q, abs_d;
  logic               pad_q, pad_d;
  logic [7:0]         dx_q, dx_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   line_q, line_d;
  logic               fin_q, fin_d;

  logic [23:0]        pal_mem [PALETTE_DEPTH];
  logic               out_valid_q;
  logic [23:0]        out_off_q;
  logic [7:0]         out_len_q;
  logic [23:0]        out_rgb_q;
  logic               out_done_q;

  logic               advance;
  logic               byte_go;
  logic               at_end;
  logic [7:0]         b;
  logic [SUM_W-1:0]   total_x, pos_x, room_x, cnt_x, line_n, pos_n;
  logic               emit;
  logic [23:0]        res_off;
  logic [7:0]         res_len;
  logic               res_done;
  logic               rd_en;
  logic               pal_we;
  logic [7:0]         run_cnt;
  logic               run_done;

  assign advance   = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = advance;
  assign b         = cmd_i.data_byte;
  assign total_x   = SUM_W'(img_total_i);
  assign pos_x     = SUM_W'(pos_q);
  assign at_end    = pos_x >= total_x;
  assign byte_go   = advance && (cmd_i.kind == CMD_BYTE) && !fin_q && !at_end;
  assign pal_we    = advance && (cmd_i.kind == CMD_PALETTE) &&
                     (int'(cmd_i.pal_index) < PALETTE_DEPTH);

  assign run_cnt  = (phase_q == PH_ABS) ? 8'd1 : pend_q;
  assign room_x   = total_x - pos_x;
  assign cnt_x    = SUM_W'(run_cnt);
  assign run_done = cnt_x >= room_x;

  // next parser phase
  always_comb begin
    phase_d = phase_q;
    if (advance && cmd_i.kind == CMD_START) begin
      phase_d = PH_COUNT;
    end else if (byte_go) begin
      unique case (phase_q)
        PH_COUNT:  phase_d = (b != 8'd0) ? PH_COLOR : PH_ESCAPE;
        PH_COLOR:  phase_d = PH_COUNT;
        PH_ESCAPE: begin
          priority if (b == ESC_DELTA) begin
            phase_d = PH_DX;
          end else if (b == ESC_EOL || b == ESC_EOI) begin
            phase_d = PH_COUNT;
          end else begin
            phase_d = PH_ABS;
          end
        end
        PH_DX:     phase_d = PH_DY;
        PH_DY:     phase_d = PH_COUNT;
        PH_ABS: begin
          if (abs_q == 8'd1) begin
            phase_d = pad_q ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD:    phase_d = PH_COUNT;
        default:   phase_d = PH_COUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    pend_d   = pend_q;
    abs_d    = abs_q;
    pad_d    = pad_q;
    dx_d     = dx_q;
    pos_d    = pos_q;
    line_d   = line_q;
    fin_d    = fin_q;
    emit     = 1'b0;
    res_off  = '0;
    res_len  = '0;
    res_done = 1'b0;
    rd_en    = 1'b0;
    line_n   = SUM_W'(line_q) + SUM_W'(img_width_i);
    pos_n    = line_n;
    if (phase_q == PH_DY) begin
      line_n = SUM_W'(line_q) + SUM_W'(cmd_i.row_step);
      pos_n  = pos_x + SUM_W'(cmd_i.row_step) + SUM_W'(dx_q);
    end
    if (advance && cmd_i.kind == CMD_START) begin
      pend_d = '0;
      abs_d  = '0;
      pad_d  = 1'b0;
      dx_d   = '0;
      pos_d  = '0;
      line_d = '0;
      fin_d  = 1'b0;
    end else if (advance && cmd_i.kind == CMD_BYTE && !fin_q && at_end) begin
      pos_d    = img_total_i;
      fin_d    = 1'b1;
      emit     = 1'b1;
      res_done = 1'b1;
    end else if (byte_go) begin
      unique case (phase_q)
        PH_COUNT: begin
          if (b != 8'd0) begin
            pend_d = b;
          end
        end
        PH_ESCAPE: begin
          priority if (b == ESC_EOL) begin
            line_d = (line_n > total_x) ? img_total_i : POS_W'(line_n);
            pos_d  = (line_n > total_x) ? img_total_i : POS_W'(line_n);
            if (line_n >= total_x) begin
              fin_d    = 1'b1;
              emit     = 1'b1;
              res_done = 1'b1;
            end
          end else if (b == ESC_EOI) begin
            fin_d    = 1'b1;
            emit     = 1'b1;
            res_done = 1'b1;
          end else if (b == ESC_DELTA) begin
            pend_d = pend_q;
          end else begin
            abs_d = b;
            pad_d = b[0];
          end
        end
        PH_DX: dx_d = b;
        PH_DY: begin
          line_d = (line_n > total_x) ? img_total_i : POS_W'(line_n);
          pos_d  = (pos_n >= total_x) ? img_total_i : POS_W'(pos_n);
          if (pos_n >= total_x) begin
            fin_d    = 1'b1;
            emit     = 1'b1;
            res_done = 1'b1;
          end
        end
        PH_COLOR, PH_ABS: begin
          if (phase_q == PH_ABS) begin
            abs_d = abs_q - 8'd1;
          end
          emit     = 1'b1;
          res_off  = 24'(pos_q);
          res_len  = run_done ? 8'(room_x) : run_cnt;
          res_done = run_done;
          rd_en    = int'(b) < PALETTE_DEPTH;
          pos_d    = run_done ? img_total_i : POS_W'(pos_x + cnt_x);
          fin_d    = run_done;
        end
        PH_PAD: pad_d = 1'b0;
        default: pend_d = pend_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COUNT;
      pend_q      <= '0;
      abs_q       <= '0;
      pad_q       <= 1'b0;
      dx_q        <= '0;
      pos_q       <= '0;
      line_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      abs_q   <= abs_d;
      pad_q   <= pad_d;
      dx_q    <= dx_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      fin_q   <= fin_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[cmd_i.pal_index[PAL_AW-1:0]] <= cmd_i.pal_rgb;
    end
    if (emit) begin
      out_off_q  <= res_off;
      out_len_q  <= res_len;
      out_done_q <= res_done;
      if (rd_en) begin
        out_rgb_q <= pal_mem[b[PAL_AW-1:0]];
      end else begin
        out_rgb_q <= '0;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.pixel_offset = out_off_q;
  assign out_data_o.run_length   = out_len_q;
  assign out_data_o.red          = out_rgb_q[23:16];
  assign out_data_o.green        = out_rgb_q[15:8];
  assign out_data_o.blue         = out_rgb_q[7:0];
  assign out_data_o.alpha        = ALPHA_OPAQUE;
  assign out_data_o.image_done   = out_done_q;

  `BMP_ASSERT(a_line_behind_pos, fin_q || (line_q <= pos_q), "line start ahead of position")
  `BMP_ASSERT(a_abs_nonzero, (phase_q != PH_ABS) || (abs_q != 8'd0), "empty absolute run")
  `BMP_ASSERT(a_empty_run_ends, !out_valid_q || (out_len_q != 8'd0) || out_done_q, "empty run")
  `BMP_ASSERT_NEXT(a_quiet_after_end, advance && fin_q && cmd_i.kind == CMD_BYTE, fin_q && !emit, "late run")

endmodule

// ----- design/bmp_rle8_decoder_core.sv -----
// Top level of the BMP RLE8 decoder: configuration registers, front and back.
// Depends on bmprle8_pkg, bmprle8_front and bmprle8_back.
//
//   port group   dir  handshake             payload
//   in_*         in   in_valid_i/in_stall_o  bmprle8_in_t
//   out_*        out  out_valid_o/out_stall_i bmprle8_out_t
//   cfg_*        in   cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless stalled; beats are queued, then results are registered.
// The two-entry command queue and the single result register set the stall behaviour.
// The palette has no reset and must be written before it is read.
// Reset sets width and height to one and clears the parser; no clearing pass.
module bmp_rle8_decoder_core import bmprle8_pkg::*; #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bmprle8_in_t      in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bmprle8_out_t     out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int WMAX    = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
  localparam int HMAX    = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
  localparam int POS_W   = $clog2(WMAX * HMAX + 1);
  localparam int MUL_W   = 2 * CFG_W;

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic [POS_W-1:0] total_q, total_d;
  logic [CFG_W-1:0] clamp_w, clamp_h;
  logic             cmd_valid;
  bmprle8_cmd_t     cmd;
  logic             cmd_pop;

  always_comb begin
    clamp_w = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      clamp_w = CFG_W'(1);
    end else if (int'(cfg_wdata_i) > WMAX) begin
      clamp_w = CFG_W'(WMAX);
    end
    clamp_h = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      clamp_h = CFG_W'(1);
    end else if (int'(cfg_wdata_i) > HMAX) begin
      clamp_h = CFG_W'(HMAX);
    end
    width_d  = width_q;
    height_d = height_q;
    total_d  = total_q;
    if (cfg_we_i && cfg_idx_i == REG_IMAGE_WIDTH) begin
      width_d = clamp_w;
      total_d = POS_W'(MUL_W'(clamp_w) * MUL_W'(height_q));
    end else if (cfg_we_i && cfg_idx_i == REG_IMAGE_HEIGHT) begin
      height_d = clamp_h;
      total_d  = POS_W'(MUL_W'(width_q) * MUL_W'(clamp_h));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
      total_q  <= POS_W'(1);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      total_q  <= total_d;
    end
  end

  bmprle8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .img_width_i (width_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bmprle8_back #(
    .POS_W         (POS_W),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .img_width_i (width_q),
    .img_total_i (total_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- test/bmp_rle8_decoder_core_tb.sv -----
// Testbench for bmp_rle8_decoder_core: drives palette loads, RLE8 byte streams and image
// starts, predicts every pixel run in a behavioural decoder and checks each output beat.
// Depends on bmprle8_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module bmp_rle8_decoder_core_tb;
  import bmprle8_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         DIM_MAX     = 4096;
  localparam int         SETTLE_CYC  = 8;
  localparam int         STALL_LIMIT = 2000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  bmprle8_in_t        in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bmprle8_out_t       out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_idx_i   = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;

  // Decoder state as the testbench sees it
  logic [CFG_W-1:0]   cfg_width    = 13'd1;
  logic [CFG_W-1:0]   cfg_height   = 13'd1;
  phase_e             parse_state  = PH_COUNT;
  logic [7:0]         run_count    = '0;
  logic [7:0]         abs_left     = '0;
  logic               pad_due      = 1'b0;
  logic [7:0]         delta_col    = '0;
  logic [31:0]        pixel_pos    = '0;
  logic [31:0]        row_base     = '0;
  logic               image_closed = 1'b0;
  logic [23:0]        palette_rgb [256];
  bit                 palette_known [256];
  logic [7:0]         known_colours [$];

  bmprle8_out_t       expected_runs [$];
  bmprle8_out_t       want;
  int                 error_count  = 0;
  int                 quiet_cycles = 0;
  int                 accepted_items = 0;
  bit                 gaps_on = 1'b1;

  bmp_rle8_decoder_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 9);
  end

  function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 32'd1;
    if (v > DIM_MAX) return DIM_MAX;
    return {19'd0, v};
  endfunction

  function automatic logic [7:0] pick_colour();
    return known_colours[$urandom_range(known_colours.size() - 1)];
  endfunction

  task automatic end_image();
    bmprle8_out_t r;
    image_closed = 1'b1;
    r = '0;
    r.alpha = ALPHA_OPAQUE;
    r.image_done = 1'b1;
    expected_runs.push_back(r);
  endtask

  task automatic settle_move(input logic [31:0] total);
    if (row_base > total) row_base = total;
    if (pixel_pos >= total) begin
      pixel_pos = total;
      end_image();
    end
  endtask

  task automatic emit_run(input logic [31:0] count, input logic [7:0] idx,
                          input logic [31:0] total);
    bmprle8_out_t r;
    logic [31:0]  room;
    logic [31:0]  len;
    logic [31:0]  first;
    room = total - pixel_pos;
    len = (count < room) ? count : room;
    first = pixel_pos;
    pixel_pos = pixel_pos + len;
    if (pixel_pos >= total) image_closed = 1'b1;
    r.pixel_offset = first[23:0];
    r.run_length = len[7:0];
    {r.red, r.green, r.blue} = palette_rgb[idx];
    r.alpha = ALPHA_OPAQUE;
    r.image_done = (pixel_pos >= total);
    expected_runs.push_back(r);
  endtask

  task automatic predict_runs(input bmprle8_in_t it);
    logic [31:0] w;
    logic [31:0] total;
    logic [7:0]  b;
    w = clamp_dim(cfg_width);
    total = w * clamp_dim(cfg_height);
    b = it.data_byte;
    case (it.operation)
      OP_PALETTE: begin
        accepted_items++;
        palette_rgb[it.palette_index] = {it.palette_red, it.palette_green, it.palette_blue};
        if (!palette_known[it.palette_index]) begin
          palette_known[it.palette_index] = 1'b1;
          known_colours.push_back(it.palette_index);
        end
      end
      OP_START: begin
        accepted_items++;
        parse_state = PH_COUNT;
        run_count = '0;
        abs_left = '0;
        pad_due = 1'b0;
        delta_col = '0;
        pixel_pos = '0;
        row_base = '0;
        image_closed = 1'b0;
      end
      OP_BYTE: if (!image_closed) begin
        accepted_items++;
        if (pixel_pos >= total) begin
          pixel_pos = total;
          end_image();
        end else begin
          case (parse_state)
            PH_COUNT: begin
              if (b != 0) begin
                run_count = b;
                parse_state = PH_COLOR;
              end else begin
                parse_state = PH_ESCAPE;
              end
            end
            PH_COLOR: begin
              parse_state = PH_COUNT;
              emit_run({24'd0, run_count}, b, total);
            end
            PH_ESCAPE: begin
              parse_state = PH_COUNT;
              if (b == ESC_EOL) begin
                row_base = row_base + w;
                pixel_pos = row_base;
                settle_move(total);
              end else if (b == ESC_EOI) begin
                end_image();
              end else if (b == ESC_DELTA) begin
                parse_state = PH_DX;
              end else begin
                abs_left = b;
                pad_due = b[0];
                parse_state = PH_ABS;
              end
            end
            PH_DX: begin
              delta_col = b;
              parse_state = PH_DY;
            end
            PH_DY: begin
              parse_state = PH_COUNT;
              row_base = row_base + b * w;
              pixel_pos = pixel_pos + b * w + delta_col;
              settle_move(total);
            end
            PH_ABS: begin
              abs_left = abs_left - 8'd1;
              if (abs_left == 0) parse_state = pad_due ? PH_PAD : PH_COUNT;
              emit_run(32'd1, b, total);
            end
            PH_PAD: begin
              pad_due = 1'b0;
              parse_state = PH_COUNT;
            end
            default: parse_state = PH_COUNT;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input bmprle8_in_t it);
    logic [31:0] total;
    total = clamp_dim(cfg_width) * clamp_dim(cfg_height);
    // steer palette reads to entries already loaded
    if (it.operation == OP_BYTE && !image_closed && pixel_pos < total &&
        (parse_state == PH_COLOR || parse_state == PH_ABS) && !palette_known[it.data_byte])
      it.data_byte = pick_colour();
    while (gaps_on && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_runs(it);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] b);
    bmprle8_in_t it;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    it = noise[$bits(bmprle8_in_t)-1:0];
    it.operation = op;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
    bmprle8_in_t it;
    it.operation = OP_PALETTE;
    it.data_byte = 8'($urandom_range(255));
    it.palette_index = idx;
    {it.palette_red, it.palette_green, it.palette_blue} = rgb;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cfg_width = value;
    else cfg_height = value;
  endtask

  task automatic test_directed_stream();
    write_register(REG_IMAGE_WIDTH, 13'd8);
    write_register(REG_IMAGE_HEIGHT, 13'd4);
    send_palette(8'h00, 24'h000000);
    send_palette(8'hFF, 24'hFFFFFF);
    send_palette(8'h5A, 24'h123456);
    send_item({OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_op(OP_START, 8'h00);
    send_op(OP_BYTE, 8'd3);
    send_op(OP_BYTE, 8'hFF);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, ESC_EOL);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, ESC_DELTA);
    send_op(OP_BYTE, 8'd3);
    send_op(OP_BYTE, 8'd1);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, 8'd3);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, 8'hFF);
    send_op(OP_BYTE, 8'h5A);
    send_op(OP_BYTE, 8'h77);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, ESC_EOI);
    send_op(OP_BYTE, 8'd7);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_START, 8'h00);
    send_op(OP_BYTE, 8'd255);
    send_op(OP_BYTE, 8'h00);
  endtask

  task automatic test_palette_fill();
    for (int k = 0; k < 256; k++) send_palette(k[7:0], 24'($urandom));
  endtask

  task automatic test_register_extremes();
    write_register(REG_IMAGE_WIDTH, 13'd8191);
    write_register(REG_IMAGE_HEIGHT, 13'd8191);
    send_op(OP_START, 8'h00);
    send_op(OP_BYTE, 8'd255);
    send_op(OP_BYTE, pick_colour());
    for (int k = 0; k < 17; k++) begin
      if (k == 16) begin
        send_op(OP_BYTE, 8'd255);
        send_op(OP_BYTE, pick_colour());
      end
      send_op(OP_BYTE, 8'h00);
      send_op(OP_BYTE, ESC_DELTA);
      send_op(OP_BYTE, 8'd255);
      send_op(OP_BYTE, 8'd255);
    end
    write_register(REG_IMAGE_WIDTH, 13'd0);
    write_register(REG_IMAGE_HEIGHT, 13'd0);
    send_op(OP_START, 8'h00);
    send_op(OP_BYTE, 8'd5);
    send_op(OP_BYTE, pick_colour());
    send_op(OP_BYTE, 8'd5);
    // shrink the frame under a half-drawn image
    write_register(REG_IMAGE_WIDTH, 13'd16);
    write_register(REG_IMAGE_HEIGHT, 13'd16);
    send_op(OP_START, 8'h00);
    send_op(OP_BYTE, 8'd200);
    send_op(OP_BYTE, pick_colour());
    write_register(REG_IMAGE_HEIGHT, 13'd4);
    send_op(OP_BYTE, 8'd9);
    send_op(OP_BYTE, 8'd9);
  endtask

  task automatic send_random_sequence();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (image_closed && pick < 85) begin
      send_op(OP_START, 8'($urandom_range(255)));
    end else if (pick < 40) begin
      send_op(OP_BYTE, 8'(($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                    : $urandom_range(1, 20)));
      send_op(OP_BYTE, pick_colour());
    end else if (pick < 50) begin
      send_op(OP_BYTE, 8'h00);
      send_op(OP_BYTE, ESC_EOL);
    end else if (pick < 58) begin
      send_op(OP_BYTE, 8'h00);
      send_op(OP_BYTE, ESC_DELTA);
      send_op(OP_BYTE, 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                    : $urandom_range(7)));
      send_op(OP_BYTE, 8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                    : $urandom_range(2)));
    end else if (pick < 78) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
      send_op(OP_BYTE, 8'h00);
      send_op(OP_BYTE, n[7:0]);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99) < 2) begin
          send_op(OP_START, 8'($urandom_range(255)));
          return;
        end
        send_op(OP_BYTE, pick_colour());
      end
      if (n[0]) send_op(OP_BYTE, 8'($urandom_range(255)));
    end else if (pick < 81) begin
      send_op(OP_BYTE, 8'h00);
      send_op(OP_BYTE, ESC_EOI);
    end else if (pick < 86) begin
      send_op(OP_START, 8'($urandom_range(255)));
    end else if (pick < 92) begin
      send_palette(8'($urandom_range(255)), 24'($urandom));
    end else if (pick < 96) begin
      send_op(OP_BYTE, 8'($urandom_range(255)));
    end else if (pick < 98) begin
      send_op(OP_UNUSED, 8'($urandom_range(255)));
    end else begin
      drain_results();
    end
  endtask

  task automatic test_random_images();
    logic [CFG_W-1:0] wdt;
    logic [CFG_W-1:0] hgt;
    int               goal;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          wdt = 13'd4096;
          hgt = 13'd1;
        end
        1: begin
          wdt = 13'd1;
          hgt = 13'd4096;
        end
        2: begin
          wdt = 13'd8191;
          hgt = 13'd2;
        end
        default: begin
          wdt = CFG_W'($urandom_range(1, 40));
          hgt = CFG_W'($urandom_range(1, 12));
        end
      endcase
      write_register(REG_IMAGE_WIDTH, wdt);
      write_register(REG_IMAGE_HEIGHT, hgt);
      gaps_on = (ph != 5);
      if ($urandom_range(9) < 7) send_op(OP_START, 8'($urandom_range(255)));
      goal = accepted_items + 90;
      while (accepted_items < goal) send_random_sequence();
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_runs.size() == 0) begin
        if (error_count < 10)
          $display("%0t unexpected run beat: off=%h len=%h end=%b", $time,
                   out_data_o.pixel_offset, out_data_o.run_length, out_data_o.image_done);
        error_count++;
      end else begin
        want = expected_runs.pop_front();
        if (out_data_o.pixel_offset !== want.pixel_offset ||
            out_data_o.run_length !== want.run_length ||
            out_data_o.red !== want.red || out_data_o.green !== want.green ||
            out_data_o.blue !== want.blue || out_data_o.alpha !== want.alpha ||
            out_data_o.image_done !== want.image_done) begin
          if (error_count < 10) begin
            $display("%0t run mismatch: want off=%h len=%h rgb=%h%h%h a=%h end=%b", $time,
                     want.pixel_offset, want.run_length, want.red, want.green, want.blue,
                     want.alpha, want.image_done);
            $display("%0t                got off=%h len=%h rgb=%h%h%h a=%h end=%b", $time,
                     out_data_o.pixel_offset, out_data_o.run_length, out_data_o.red,
                     out_data_o.green, out_data_o.blue, out_data_o.alpha,
                     out_data_o.image_done);
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_stream();
    test_palette_fill();
    test_register_extremes();
    test_random_images();
    drain_results();
    if (error_count == 0 && expected_runs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- bmp_rle8_decoder_core.f -----
+incdir+design
design/bmprle8_pkg.sv
design/bmprle8_front.sv
design/bmprle8_back.sv
design/bmp_rle8_decoder_core.sv
test/bmp_rle8_decoder_core_tb.sv
